// ===== rtl/weighted_gray_contrast_pixel_core_assert.svh =====
`ifndef WEIGHTED_GRAY_CONTRAST_PIXEL_CORE_ASSERT_SVH
`define WEIGHTED_GRAY_CONTRAST_PIXEL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/wgcp_pkg.sv =====
package wgcp_pkg;

	localparam int CH_W      = 8;
	localparam int REG_W     = 16;
	localparam int PROD_W    = 24;
	localparam int ACC_W     = 26;
	localparam int SCALED_W  = 42;
	localparam int SHIFT_W   = 20;
	localparam int LVL_W     = 8;
	localparam int NUM_W     = 26;
	localparam int FRAC_W    = 9;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;
	localparam int DATA_W    = 32;

	localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_RED_W    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GREEN_W  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLUE_W   = 3'd3;
	localparam logic [IDX_W-1:0] REG_ALPHA_W  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCALE    = 3'd5;
	localparam logic [IDX_W-1:0] REG_CONTRAST = 3'd6;

	localparam logic MODE_AVG = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	localparam logic [REG_W-1:0] RST_COLOR_W  = 16'd4096;
	localparam logic [REG_W-1:0] RST_ALPHA_W  = 16'd0;
	localparam logic [REG_W-1:0] RST_SCALE    = 16'd256;
	localparam logic [REG_W-1:0] RST_CONTRAST = 16'd256;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [LVL_W-1:0] LVL_MAX     = 8'd255;
	localparam logic [9:0]       THIRD_LIMIT = 10'd768;
	localparam logic [19:0]      RECIP3      = 20'd683;
	localparam logic signed [NUM_W-1:0] MID_OFFSET = 26'sd65280;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] gray_out;
		logic [CH_W-1:0] alpha_out;
	} pix_out_t;

	typedef struct packed {
		logic                    combine_mode;
		logic [REG_W-1:0]        red_weight;
		logic [REG_W-1:0]        green_weight;
		logic [REG_W-1:0]        blue_weight;
		logic [REG_W-1:0]        alpha_weight;
		logic [REG_W-1:0]        brightness_scale;
		logic signed [REG_W-1:0] contrast_gain;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [CH_W-1:0]  alpha;
	} q_word_t;

endpackage

// ===== rtl/wgcp_regs.sv =====
module wgcp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wgcp_pkg::ADDR_W-1:0]  paddr,
	input  logic [wgcp_pkg::DATA_W-1:0]  pwdata,
	output logic [wgcp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output wgcp_pkg::cfg_t               cfg
);
	import wgcp_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.combine_mode     <= MODE_AVG;
			cfg_q.red_weight       <= RST_COLOR_W;
			cfg_q.green_weight     <= RST_COLOR_W;
			cfg_q.blue_weight      <= RST_COLOR_W;
			cfg_q.alpha_weight     <= RST_ALPHA_W;
			cfg_q.brightness_scale <= RST_SCALE;
			cfg_q.contrast_gain    <= RST_CONTRAST;
		end else if (wr) begin
			unique case (idx)
				REG_MODE:     cfg_q.combine_mode     <= pwdata[0];
				REG_RED_W:    cfg_q.red_weight       <= pwdata[REG_W-1:0];
				REG_GREEN_W:  cfg_q.green_weight     <= pwdata[REG_W-1:0];
				REG_BLUE_W:   cfg_q.blue_weight      <= pwdata[REG_W-1:0];
				REG_ALPHA_W:  cfg_q.alpha_weight     <= pwdata[REG_W-1:0];
				REG_SCALE:    cfg_q.brightness_scale <= pwdata[REG_W-1:0];
				REG_CONTRAST: cfg_q.contrast_gain    <= pwdata[REG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE:     prdata = DATA_W'(cfg_q.combine_mode);
			REG_RED_W:    prdata = DATA_W'(cfg_q.red_weight);
			REG_GREEN_W:  prdata = DATA_W'(cfg_q.green_weight);
			REG_BLUE_W:   prdata = DATA_W'(cfg_q.blue_weight);
			REG_ALPHA_W:  prdata = DATA_W'(cfg_q.alpha_weight);
			REG_SCALE:    prdata = DATA_W'(cfg_q.brightness_scale);
			REG_CONTRAST: prdata = DATA_W'(unsigned'(cfg_q.contrast_gain));
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/wgcp_front.sv =====
module wgcp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  wgcp_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  wgcp_pkg::pix_in_t  in_word,
	output logic               q_valid,
	input  logic               q_ready,
	output wgcp_pkg::q_word_t  q_word
);
	import wgcp_pkg::*;

	logic              vld_s1;
	logic [PROD_W-1:0] p_s1 [4];
	logic [CH_W-1:0]   alpha_s1;
	logic [PROD_W-1:0] max_ab;
	logic [PROD_W-1:0] max_cd;

	assign in_ready = !vld_s1 || q_ready;
	assign q_valid  = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_s1[0]  <= PROD_W'(in_word.red_in) * PROD_W'(cfg.red_weight);
			p_s1[1]  <= PROD_W'(in_word.green_in) * PROD_W'(cfg.green_weight);
			p_s1[2]  <= PROD_W'(in_word.blue_in) * PROD_W'(cfg.blue_weight);
			p_s1[3]  <= PROD_W'(in_word.alpha_in) * PROD_W'(cfg.alpha_weight);
			alpha_s1 <= in_word.alpha_in;
		end
	end

	assign max_ab = (p_s1[0] >= p_s1[1]) ? p_s1[0] : p_s1[1];
	assign max_cd = (p_s1[2] >= p_s1[3]) ? p_s1[2] : p_s1[3];

	always_comb begin
		q_word.alpha = alpha_s1;
		if (cfg.combine_mode == MODE_MAX) begin
			q_word.acc = ACC_W'((max_ab >= max_cd) ? max_ab : max_cd);
		end else begin
			q_word.acc = ACC_W'(p_s1[0]) + ACC_W'(p_s1[1]) + ACC_W'(p_s1[2])
				+ ACC_W'(p_s1[3]);
		end
	end

endmodule

// ===== rtl/wgcp_fifo.sv =====
`include "weighted_gray_contrast_pixel_core_assert.svh"
module wgcp_fifo #(
	parameter int DEPTH = wgcp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wgcp_pkg::q_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output wgcp_pkg::q_word_t  out_word
);
	import wgcp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_word_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr;
	logic             rd;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_word  = mem_q[rd_ptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= in_word;
		end
	end

	`ASSERT_NEXT(a_fill, clk, arst_n, wr && !rd, count_q == $past(count_q) + 1'b1)
	`ASSERT_NEXT(a_drain, clk, arst_n, rd && !wr, count_q == $past(count_q) - 1'b1)

endmodule

// ===== rtl/wgcp_back.sv =====
`include "weighted_gray_contrast_pixel_core_assert.svh"
module wgcp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wgcp_pkg::cfg_t     cfg,
	input  logic               q_valid,
	output logic               q_ready,
	input  wgcp_pkg::q_word_t  q_word,
	output logic               out_valid,
	input  logic               out_ready,
	output wgcp_pkg::pix_out_t out_word
);
	import wgcp_pkg::*;

	localparam int T_W = SCALED_W - SHIFT_W;

	logic                       vld_s1, vld_s2, vld_s3;
	logic                       rdy_s1, rdy_s2, rdy_s3, rdy_o;
	logic [SCALED_W-1:0]        scaled_s1;
	logic [CH_W-1:0]            alpha_s1, alpha_s2, alpha_s3;
	logic [LVL_W-1:0]           lvl_s2;
	logic signed [NUM_W-1:0]    num_s3;
	logic                       out_valid_q;
	pix_out_t                   out_word_q;

	logic [T_W-1:0]             t;
	logic [T_W-1:0]             t_sh;
	logic [2:0]                 n_cnt;
	logic [19:0]                third;
	logic [LVL_W-1:0]           lvl;
	logic signed [9:0]          dev;
	logic [CH_W-1:0]            gray;

	assign rdy_o   = !out_valid_q || out_ready;
	assign rdy_s3  = !vld_s3 || rdy_o;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign q_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= q_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_o)  out_valid_q <= vld_s3;
		end
	end

	// divisor is the count of nonzero weights in average mode
	always_comb begin
		if (cfg.combine_mode == MODE_MAX) begin
			n_cnt = 3'd1;
		end else begin
			n_cnt = 3'(cfg.red_weight != '0) + 3'(cfg.green_weight != '0)
				+ 3'(cfg.blue_weight != '0) + 3'(cfg.alpha_weight != '0);
		end
	end

	assign t     = scaled_s1[SCALED_W-1:SHIFT_W];
	assign third = 20'(t[9:0]) * RECIP3;

	always_comb begin
		t_sh = t;
		lvl  = '0;
		unique case (n_cnt)
			3'd2:    t_sh = t >> 1;
			3'd4:    t_sh = t >> 2;
			default: t_sh = t;
		endcase
		if (n_cnt == 3'd3) begin
			lvl = (t >= T_W'(THIRD_LIMIT)) ? LVL_MAX : third[18:11];
		end else begin
			lvl = (t_sh > T_W'(LVL_MAX)) ? LVL_MAX : t_sh[LVL_W-1:0];
		end
	end

	assign dev = signed'({1'b0, lvl_s2, 1'b0}) - 10'sd255;

	always_comb begin
		if (num_s3 < 0) begin
			gray = '0;
		end else if (num_s3[NUM_W-1:FRAC_W] > (NUM_W - FRAC_W)'(LVL_MAX)) begin
			gray = LVL_MAX;
		end else begin
			gray = num_s3[FRAC_W+CH_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && rdy_s1) begin
			scaled_s1 <= SCALED_W'(q_word.acc) * SCALED_W'(cfg.brightness_scale);
			alpha_s1  <= q_word.alpha;
		end
		if (vld_s1 && rdy_s2) begin
			lvl_s2   <= lvl;
			alpha_s2 <= alpha_s1;
		end
		if (vld_s2 && rdy_s3) begin
			num_s3   <= NUM_W'(dev) * NUM_W'(cfg.contrast_gain) + MID_OFFSET;
			alpha_s3 <= alpha_s2;
		end
		if (vld_s3 && rdy_o) begin
			out_word_q.gray_out  <= gray;
			out_word_q.alpha_out <= alpha_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`ASSERT_NEXT(a_adv_s2, clk, arst_n, vld_s1 && rdy_s2, vld_s2)
	`ASSERT_NEXT(a_clamp_low, clk, arst_n, vld_s3 && rdy_o && num_s3[NUM_W-1], out_word.gray_out == '0)

endmodule

// ===== rtl/weighted_gray_contrast_pixel_core.sv =====
// path: a pixel word is registered by the front product stage, the queue,
// back stages s1, s2, s3 and the output register, in that order
// throughput: one pixel word per cycle unless out_ready stalls the output
// reset: arst_n clears all valid flags and queue pointers at once and loads
// the register defaults; payload registers are not reset
module weighted_gray_contrast_pixel_core #(
	parameter int QUEUE_DEPTH = wgcp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wgcp_pkg::ADDR_W-1:0]  paddr,
	input  logic [wgcp_pkg::DATA_W-1:0]  pwdata,
	output logic [wgcp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wgcp_pkg::pix_in_t            in_word,
	output logic                         out_valid,
	input  logic                         out_ready,
	output wgcp_pkg::pix_out_t           out_word
);
	import wgcp_pkg::*;

	cfg_t    cfg;
	q_word_t fq_word, bq_word;
	logic    fq_valid, fq_ready, bq_valid, bq_ready;

	wgcp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wgcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_word   (fq_word)
	);

	wgcp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_word   (fq_word),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_word  (bq_word)
	);

	wgcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (bq_valid),
		.q_ready   (bq_ready),
		.q_word    (bq_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import wgcp_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
	localparam int NUM_PHASES = 10;
	localparam int PIXELS_PER_PHASE = 220;
	localparam int NUM_CORNERS = 12;
	localparam int LONG_STALL = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam longint CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_in_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_word;

	cfg_t shadow_cfg;
	pix_in_t pixel_backlog[$];
	pix_out_t gray_due[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	longint cycles = 0;
	bit in_fire = 1'b0;
	int stall_req = 0;
	int stall_served = 0;
	int stall_left = 0;

	pix_in_t corner_pix [NUM_CORNERS] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_0000,
		32'h0000_FF00, 32'h0000_00FF, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h0102_0408, 32'h8040_2010, 32'hFFFF_FF00, 32'h7F80_01FE
	};

	weighted_gray_contrast_pixel_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	function automatic pix_out_t gray_pixel_of(input pix_in_t pix, input cfg_t cfg);
		longint unsigned chan [4];
		longint unsigned wt [4];
		longint unsigned prod;
		longint unsigned acc;
		longint unsigned cnt;
		longint unsigned lvl;
		longint signed gain;
		longint signed num;
		pix_out_t res;
		chan[0] = 64'(pix.red_in);
		chan[1] = 64'(pix.green_in);
		chan[2] = 64'(pix.blue_in);
		chan[3] = 64'(pix.alpha_in);
		wt[0] = 64'(cfg.red_weight);
		wt[1] = 64'(cfg.green_weight);
		wt[2] = 64'(cfg.blue_weight);
		wt[3] = 64'(cfg.alpha_weight);
		acc = 0;
		cnt = 0;
		for (int i = 0; i < 4; i++) begin
			prod = chan[i] * wt[i];
			if (cfg.combine_mode == MODE_MAX) begin
				if (prod > acc)
					acc = prod;
			end else begin
				acc += prod;
				if (wt[i] != 0)
					cnt++;
			end
		end
		if (cnt == 0)
			cnt = 1;
		lvl = (acc * cfg.brightness_scale) / (cnt << SHIFT_W);
		if (lvl > LVL_MAX)
			lvl = 64'(LVL_MAX);
		gain = $signed(cfg.contrast_gain);
		num = (2 * longint'(lvl) - 255) * gain + MID_OFFSET;
		res.alpha_out = pix.alpha_in;
		if (num < 0)
			res.gray_out = '0;
		else if (num / (1 << FRAC_W) > 255)
			res.gray_out = LVL_MAX;
		else
			res.gray_out = CH_W'(num / (1 << FRAC_W));
		return res;
	endfunction

	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
		REG_MODE: shadow_cfg.combine_mode = data[0];
		REG_RED_W: shadow_cfg.red_weight = data[REG_W-1:0];
		REG_GREEN_W: shadow_cfg.green_weight = data[REG_W-1:0];
		REG_BLUE_W: shadow_cfg.blue_weight = data[REG_W-1:0];
		REG_ALPHA_W: shadow_cfg.alpha_weight = data[REG_W-1:0];
		REG_SCALE: shadow_cfg.brightness_scale = data[REG_W-1:0];
		REG_CONTRAST: shadow_cfg.contrast_gain = data[REG_W-1:0];
		default: ;
		endcase
	endtask

	task automatic setup_phase(input int ph);
		logic [DATA_W-1:0] v [7];
		for (int i = 0; i < 7; i++)
			v[i] = $urandom;
		v[REG_MODE][0] = MODE_AVG;
		for (int i = REG_RED_W; i <= REG_BLUE_W; i++)
			v[i][REG_W-1:0] = RST_COLOR_W;
		v[REG_ALPHA_W][REG_W-1:0] = RST_ALPHA_W;
		v[REG_SCALE][REG_W-1:0] = RST_SCALE;
		v[REG_CONTRAST][REG_W-1:0] = RST_CONTRAST;
		case (ph)
		1: v[REG_MODE][0] = MODE_MAX;
		2: begin
			// every weight zero in average mode
			for (int i = REG_RED_W; i <= REG_ALPHA_W; i++)
				v[i][REG_W-1:0] = '0;
		end
		3: begin
			v[REG_MODE][0] = MODE_MAX;
			for (int i = REG_RED_W; i <= REG_ALPHA_W; i++)
				v[i][REG_W-1:0] = 16'hFFFF;
			v[REG_SCALE][REG_W-1:0] = 16'hFFFF;
			v[REG_CONTRAST][REG_W-1:0] = 16'h7FFF;
		end
		4: begin
			for (int i = REG_RED_W; i <= REG_ALPHA_W; i++)
				v[i][REG_W-1:0] = 16'hFFFF;
			v[REG_SCALE][REG_W-1:0] = '0;
			v[REG_CONTRAST][REG_W-1:0] = 16'h8000;
		end
		default: begin
			v[REG_MODE][0] = 1'($urandom_range(1));
			for (int i = REG_RED_W; i <= REG_ALPHA_W; i++) begin
				case ($urandom_range(4))
				0: v[i][REG_W-1:0] = '0;
				1: v[i][REG_W-1:0] = 16'hFFFF;
				2: v[i][REG_W-1:0] = RST_COLOR_W;
				3: v[i][REG_W-1:0] = REG_W'($urandom_range(8191));
				default: ;
				endcase
			end
			case ($urandom_range(4))
			0: v[REG_SCALE][REG_W-1:0] = '0;
			1: v[REG_SCALE][REG_W-1:0] = 16'hFFFF;
			2: v[REG_SCALE][REG_W-1:0] = RST_SCALE;
			3: v[REG_SCALE][REG_W-1:0] = REG_W'($urandom_range(1023));
			default: ;
			endcase
			case ($urandom_range(5))
			0: v[REG_CONTRAST][REG_W-1:0] = 16'h8000;
			1: v[REG_CONTRAST][REG_W-1:0] = 16'h7FFF;
			2: v[REG_CONTRAST][REG_W-1:0] = '0;
			3: v[REG_CONTRAST][REG_W-1:0] = RST_CONTRAST;
			4: v[REG_CONTRAST][REG_W-1:0] = REG_W'($urandom_range(2048) - 1024);
			default: ;
			endcase
		end
		endcase
		for (int i = 0; i < 7; i++)
			reg_write(IDX_W'(i), v[i]);
		reg_write(REG_NONE, $urandom);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		pix_in_t pix;
		shadow_cfg.combine_mode = MODE_AVG;
		shadow_cfg.red_weight = RST_COLOR_W;
		shadow_cfg.green_weight = RST_COLOR_W;
		shadow_cfg.blue_weight = RST_COLOR_W;
		shadow_cfg.alpha_weight = RST_ALPHA_W;
		shadow_cfg.brightness_scale = RST_SCALE;
		shadow_cfg.contrast_gain = RST_CONTRAST;
		send_idle_pct = 14;
		recv_idle_pct = 64;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 64;
				recv_idle_pct = 14;
			end
			if (ph == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph > 0)
				setup_phase(ph);
			if (ph == 5 || ph == 8)
				stall_req++;
			for (int i = 0; i < NUM_CORNERS; i++)
				pixel_backlog.push_back(corner_pix[i]);
			for (int k = 0; k < (ph == 0 ? 8 : PIXELS_PER_PHASE); k++) begin
				pix = $urandom;
				if ($urandom_range(7) == 0)
					pix.red_in = $urandom_range(1) ? 8'hFF : 8'h00;
				if ($urandom_range(7) == 0)
					pix.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
				if ($urandom_range(7) == 0)
					pix.blue_in = $urandom_range(1) ? 8'hFF : 8'h00;
				if ($urandom_range(7) == 0)
					pix.alpha_in = $urandom_range(1) ? 8'hFF : 8'h00;
				pixel_backlog.push_back(pix);
			end
			while (pixel_backlog.size() != 0 || in_valid || gray_due.size() != 0)
				@(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
		end
		if (mismatches == 0 && gray_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// pixel driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_word <= pixel_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_served <= 0;
		end else if (stall_req != stall_served) begin
			stall_served <= stall_req;
			stall_left <= LONG_STALL;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		pix_out_t want;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			gray_due.push_back(gray_pixel_of(in_word, shadow_cfg));
		if (arst_n && out_valid && out_ready) begin
			if (gray_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected gray word: gray %0d alpha %0d",
						out_word.gray_out, out_word.alpha_out);
			end else begin
				want = gray_due.pop_front();
				if (out_word.gray_out !== want.gray_out ||
						out_word.alpha_out !== want.alpha_out) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected gray %0d alpha %0d, got gray %0d alpha %0d",
							want.gray_out, want.alpha_out,
							out_word.gray_out, out_word.alpha_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wgcp_pkg.sv
rtl/wgcp_regs.sv
rtl/wgcp_front.sv
rtl/wgcp_fifo.sv
rtl/wgcp_back.sv
rtl/weighted_gray_contrast_pixel_core.sv
verif/tb.sv
